// ----- design/osa_pkg.sv -----
// ----------------------------------------------------------------------------
// osa_pkg
// Types, constants and arithmetic helpers of the online softmax attention unit.
// ----------------------------------------------------------------------------
package osa_pkg;

   localparam int MAX_HEAD_DIM_DEF = 64;

   localparam logic [6:0]  ROW_LEN_RST     = 7'd64;
   localparam logic [15:0] SCORE_SCALE_RST = 16'd8192;

   typedef enum logic {
      CSR_ROW_LEN     = 1'b0,
      CSR_SCORE_SCALE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        mode;
      logic [5:0]  elem_index;
      logic [15:0] query_elem;
      logic [15:0] key_elem;
      logic [15:0] value_elem;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_index;
      logic [15:0] out_value;
      logic        out_last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_SC_HI,
      ST_SC_LO,
      ST_SC_SUM,
      ST_EXP1,
      ST_EXP2,
      ST_EXP3,
      ST_SUM_MUL,
      ST_SUM_ADD,
      ST_LN_RD,
      ST_LN_M1,
      ST_LN_M2,
      ST_LN_WR,
      ST_OUT_RD,
      ST_OUT_DIV,
      ST_OUT_WAIT,
      ST_OUT_EMIT
   } state_type;

   localparam logic [32:0] EXP_LIMIT = 33'd786432;

   function automatic logic [16:0] exp_int(input logic [3:0] i);
      logic [16:0] r;
      case (i)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd24109;
         4'd2:    r = 17'd8869;
         4'd3:    r = 17'd3263;
         4'd4:    r = 17'd1200;
         4'd5:    r = 17'd442;
         4'd6:    r = 17'd162;
         4'd7:    r = 17'd60;
         4'd8:    r = 17'd22;
         4'd9:    r = 17'd8;
         4'd10:   r = 17'd3;
         4'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] exp_frac(input logic [3:0] i);
      logic [16:0] r;
      case (i)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd61565;
         4'd2:    r = 17'd57835;
         4'd3:    r = 17'd54331;
         4'd4:    r = 17'd51040;
         4'd5:    r = 17'd47947;
         4'd6:    r = 17'd45042;
         4'd7:    r = 17'd42313;
         4'd8:    r = 17'd39749;
         4'd9:    r = 17'd37341;
         4'd10:   r = 17'd35079;
         4'd11:   r = 17'd32954;
         4'd12:   r = 17'd30957;
         4'd13:   r = 17'd29081;
         4'd14:   r = 17'd27319;
         4'd15:   r = 17'd25664;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // bf16 to Q16.16, truncating toward zero and saturating by sign.
   function automatic logic signed [31:0] bf_to_q(input logic [15:0] b);
      logic [7:0]  e;
      logic [7:0]  s;
      logic [31:0] mag;
      logic        sat;
      logic signed [31:0] r;
      e   = b[14:7];
      mag = 32'd0;
      sat = 1'b0;
      s   = 8'd0;
      if (e == 8'd255) begin
         sat = 1'b1;
      end else if (e >= 8'd118) begin
         s = e - 8'd118;
         if (s >= 8'd24) begin
            sat = 1'b1;
         end else begin
            mag = {24'd0, 1'b1, b[6:0]} << s[4:0];
         end
      end else begin
         s = 8'd118 - e;
         if (s < 8'd8) begin
            mag = {24'd0, 1'b1, b[6:0]} >> s[2:0];
         end
      end
      if (e == 8'd0) begin
         r = 32'sd0;
      end else if (sat) begin
         r = b[15] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         r = b[15] ? -$signed(mag) : $signed(mag);
      end
      return r;
   endfunction

   // Unsigned Q16.16 magnitude to bf16, round to nearest even.
   function automatic logic [15:0] q_to_bf(input logic neg, input logic [31:0] u);
      logic [5:0]  p;
      logic [5:0]  s;
      logic [31:0] rem;
      logic [31:0] half;
      logic [8:0]  top;
      logic [7:0]  ex;
      logic [15:0] r;
      p = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (u[i]) p = 6'(i);
      end
      s    = 6'd0;
      rem  = 32'd0;
      half = 32'd0;
      if (p <= 6'd7) begin
         top = 9'(u << (6'd7 - p));
      end else begin
         s    = p - 6'd7;
         rem  = u & ((32'd1 << s) - 32'd1);
         half = 32'd1 << (s - 6'd1);
         top  = 9'(u >> s);
         if (rem > half || (rem == half && top[0])) top = top + 9'd1;
         if (top == 9'd256) begin
            top = 9'd128;
            p   = p + 6'd1;
         end
      end
      ex = 8'(p) + 8'd111;
      if (u == 32'd0) begin
         r = 16'h0000;
      end else begin
         r = {neg, ex, top[6:0]};
      end
      return r;
   endfunction

endpackage

// ----- design/osa_ram.sv -----
// ----------------------------------------------------------------------------
// osa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module osa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end

endmodule

// ----- design/osa_div.sv -----
// ----------------------------------------------------------------------------
// osa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osa_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         num_in = num;
         den_in = den;
      end else if (run_ff) begin
         // The quotient bits shift into the numerator register from the bottom.
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ----- design/online_softmax_attention_unit.sv -----
// ----------------------------------------------------------------------------
// online_softmax_attention_unit
// One query row against a frame of key/value rows with a running-max softmax.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A query element is
// written to the query RAM while the unit stays idle. A key/value element goes
// through ST_DOT_MUL and ST_DOT_ACC on the shared multiplier. The element that
// ends a row then runs the score, the exponentials (only one on the first row
// of a frame), the sum and every accumulator lane through the same single 33x33
// multiplier, each lane through ST_LN_RD, ST_LN_M1, ST_LN_M2 and ST_LN_WR. On
// the last row of a frame the D results follow, one per lane, most of the time
// spent in the bit-serial divider; with a zero running sum a lane skips it.
// Results appear on rsp_data for one cycle, marked by rsp_valid; the receiver
// cannot stall them, so it must take every strobe.
module online_softmax_attention_unit #(
   parameter int MAX_HEAD_DIM = osa_pkg::MAX_HEAD_DIM_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  osa_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   output logic             rsp_valid,
   output osa_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_HEAD_DIM);
   localparam int DIM_W = $clog2(MAX_HEAD_DIM + 1);

   osa_pkg::state_type state_ff, state_in;

   logic [6:0]              row_len_ff;
   logic [15:0]             scale_ff;
   logic signed [39:0]      dot_ff, dot_in;
   logic signed [31:0]      run_max_ff, run_max_in;
   logic [31:0]             run_sum_ff, run_sum_in;
   logic                    first_ff, first_in;
   logic [MAX_HEAD_DIM-1:0] vld_ff, vld_in;
   logic [DIM_W-1:0]        lane_ff, lane_in;

   logic [5:0]              idx_ff, idx_in;
   logic [15:0]             key_ff, key_in;
   logic                    frame_ff, frame_in;
   logic signed [65:0]      mul_p_ff;
   logic signed [65:0]      hi_p_ff, hi_p_in;
   logic signed [31:0]      score_ff, score_in;
   logic signed [31:0]      nmax_ff, nmax_in;
   logic [32:0]             exp_d_ff, exp_d_in;
   logic                    exp_sel_ff, exp_sel_in;
   logic [16:0]             alpha_ff, alpha_in;
   logic [16:0]             beta_ff, beta_in;
   logic signed [33:0]      lane_p_ff, lane_p_in;
   logic [31:0]             q_ff, q_in;
   logic                    neg_ff, neg_in;

   logic signed [32:0] mul_a, mul_b;
   logic [DIM_W-1:0]   dim;
   logic [6:0]         dim7;

   logic             q_we, v_we, a_we;
   logic [IDX_W-1:0] q_addr, v_addr, a_addr;
   logic [15:0]      q_rd, v_rd;
   logic [31:0]      a_rd, a_wdata;

   logic        div_start, div_done;
   logic [47:0] div_num, div_quot;

   logic signed [31:0] acc_o;
   logic [31:0]        mag_o;
   logic signed [31:0] pq;
   logic signed [40:0] ds;
   logic signed [65:0] full;
   logic [34:0]        sum_t;
   logic signed [31:0] sc;

   always_comb begin
      if (row_len_ff == 7'd0) begin
         dim = DIM_W'(1);
      end else if (row_len_ff > 7'(MAX_HEAD_DIM)) begin
         dim = DIM_W'(MAX_HEAD_DIM);
      end else begin
         dim = DIM_W'(row_len_ff);
      end
   end
   assign dim7 = 7'(dim);

   osa_ram #(.WIDTH(16), .DEPTH(MAX_HEAD_DIM)) u_query_ram (
      .clock(clock), .we(q_we), .addr(q_addr), .wdata(req_data.query_elem), .rdata(q_rd)
   );

   osa_ram #(.WIDTH(16), .DEPTH(MAX_HEAD_DIM)) u_value_ram (
      .clock(clock), .we(v_we), .addr(v_addr), .wdata(req_data.value_elem), .rdata(v_rd)
   );

   osa_ram #(.WIDTH(32), .DEPTH(MAX_HEAD_DIM)) u_acc_ram (
      .clock(clock), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rd)
   );

   osa_div #(.NUM_W(48), .DEN_W(32)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(run_sum_ff), .done(div_done), .quot(div_quot)
   );

   // Lanes never written since the frame began read as zero.
   assign acc_o   = vld_ff[lane_ff[IDX_W-1:0]] ? $signed(a_rd) : 32'sd0;
   assign mag_o   = acc_o[31] ? (~acc_o + 32'd1) : acc_o;
   assign div_num = {mag_o, 16'd0};

   always_comb begin
      state_in   = state_ff;
      dot_in     = dot_ff;
      run_max_in = run_max_ff;
      run_sum_in = run_sum_ff;
      first_in   = first_ff;
      vld_in     = vld_ff;
      lane_in    = lane_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      frame_in   = frame_ff;
      hi_p_in    = hi_p_ff;
      score_in   = score_ff;
      nmax_in    = nmax_ff;
      exp_d_in   = exp_d_ff;
      exp_sel_in = exp_sel_ff;
      alpha_in   = alpha_ff;
      beta_in    = beta_ff;
      lane_p_in  = lane_p_ff;
      q_in       = q_ff;
      neg_in     = neg_ff;
      mul_a      = 33'sd0;
      mul_b      = 33'sd0;
      q_we       = 1'b0;
      v_we       = 1'b0;
      a_we       = 1'b0;
      q_addr     = req_data.elem_index[IDX_W-1:0];
      v_addr     = lane_ff[IDX_W-1:0];
      a_addr     = lane_ff[IDX_W-1:0];
      a_wdata    = 32'd0;
      div_start  = 1'b0;
      rsp_valid  = 1'b0;
      pq         = 32'sd0;
      ds         = 41'sd0;
      full       = 66'sd0;
      sum_t      = 35'd0;
      sc         = 32'sd0;

      case (state_ff)
         osa_pkg::ST_IDLE: begin
            v_addr = req_data.elem_index[IDX_W-1:0];
            idx_in   = req_data.elem_index;
            key_in   = req_data.key_elem;
            frame_in = req_data.last_row;
            if (start) begin
               if (!req_data.mode) begin
                  q_we = ({1'b0, req_data.elem_index} < 7'(MAX_HEAD_DIM));
               end else if ({1'b0, req_data.elem_index} < dim7) begin
                  v_we     = 1'b1;
                  state_in = osa_pkg::ST_DOT_MUL;
               end
            end
         end
         osa_pkg::ST_DOT_MUL: begin
            mul_a    = 33'(osa_pkg::bf_to_q(q_rd));
            mul_b    = 33'(osa_pkg::bf_to_q(key_ff));
            state_in = osa_pkg::ST_DOT_ACC;
         end
         osa_pkg::ST_DOT_ACC: begin
            pq = osa_pkg::sat32(mul_p_ff >>> 16);
            ds = $signed({dot_ff[39], dot_ff}) + $signed({{9{pq[31]}}, pq});
            if (ds[40] != ds[39]) begin
               dot_in = ds[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
            end else begin
               dot_in = ds[39:0];
            end
            if ({1'b0, idx_ff} == dim7 - 7'd1) begin
               state_in = osa_pkg::ST_SC_HI;
            end else begin
               state_in = osa_pkg::ST_IDLE;
            end
         end
         osa_pkg::ST_SC_HI: begin
            mul_a    = {{13{dot_ff[39]}}, dot_ff[39:20]};
            mul_b    = {17'd0, scale_ff};
            state_in = osa_pkg::ST_SC_LO;
         end
         osa_pkg::ST_SC_LO: begin
            mul_a    = {13'd0, dot_ff[19:0]};
            mul_b    = {17'd0, scale_ff};
            hi_p_in  = mul_p_ff;
            state_in = osa_pkg::ST_SC_SUM;
         end
         osa_pkg::ST_SC_SUM: begin
            full     = (hi_p_ff <<< 20) + mul_p_ff;
            sc       = osa_pkg::sat32(full >>> 16);
            score_in = sc;
            if (first_ff) begin
               nmax_in    = sc;
               alpha_in   = 17'd0;
               exp_sel_in = 1'b1;
               exp_d_in   = 33'd0;
            end else begin
               nmax_in    = (sc > run_max_ff) ? sc : run_max_ff;
               exp_sel_in = 1'b0;
               exp_d_in   = 33'($signed({nmax_in[31], nmax_in})
                          - $signed({run_max_ff[31], run_max_ff}));
            end
            state_in = osa_pkg::ST_EXP1;
         end
         osa_pkg::ST_EXP1: begin
            mul_a    = {16'd0, osa_pkg::exp_frac(exp_d_ff[15:12])};
            mul_b    = 33'sd65536 - $signed({21'd0, exp_d_ff[11:0]});
            state_in = osa_pkg::ST_EXP2;
         end
         osa_pkg::ST_EXP2: begin
            mul_a    = {16'd0, osa_pkg::exp_int(exp_d_ff[19:16])};
            mul_b    = {16'd0, mul_p_ff[32:16]};
            state_in = osa_pkg::ST_EXP3;
         end
         osa_pkg::ST_EXP3: begin
            if (!exp_sel_ff) begin
               alpha_in   = (exp_d_ff >= osa_pkg::EXP_LIMIT) ? 17'd0 : mul_p_ff[32:16];
               exp_sel_in = 1'b1;
               exp_d_in   = 33'($signed({nmax_ff[31], nmax_ff})
                          - $signed({score_ff[31], score_ff}));
               state_in   = osa_pkg::ST_EXP1;
            end else begin
               beta_in  = (exp_d_ff >= osa_pkg::EXP_LIMIT) ? 17'd0 : mul_p_ff[32:16];
               state_in = osa_pkg::ST_SUM_MUL;
            end
         end
         osa_pkg::ST_SUM_MUL: begin
            mul_a    = {1'b0, run_sum_ff};
            mul_b    = {16'd0, alpha_ff};
            state_in = osa_pkg::ST_SUM_ADD;
         end
         osa_pkg::ST_SUM_ADD: begin
            sum_t = {1'b0, mul_p_ff[49:16]} + {18'd0, beta_ff};
            run_sum_in = (sum_t > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : sum_t[31:0];
            lane_in    = '0;
            state_in   = osa_pkg::ST_LN_RD;
         end
         osa_pkg::ST_LN_RD: begin
            state_in = osa_pkg::ST_LN_M1;
         end
         osa_pkg::ST_LN_M1: begin
            mul_a    = {acc_o[31], acc_o};
            mul_b    = {16'd0, alpha_ff};
            state_in = osa_pkg::ST_LN_M2;
         end
         osa_pkg::ST_LN_M2: begin
            lane_p_in = mul_p_ff[49:16];
            mul_a     = 33'(osa_pkg::bf_to_q(v_rd));
            mul_b     = {16'd0, beta_ff};
            state_in  = osa_pkg::ST_LN_WR;
         end
         osa_pkg::ST_LN_WR: begin
            full    = $signed({{32{lane_p_ff[33]}}, lane_p_ff}) + (mul_p_ff >>> 16);
            a_wdata = osa_pkg::sat32(full);
            a_we    = 1'b1;
            vld_in[lane_ff[IDX_W-1:0]] = 1'b1;
            if (lane_ff == dim - 1'b1) begin
               run_max_in = nmax_ff;
               first_in   = 1'b0;
               dot_in     = 40'sd0;
               lane_in    = '0;
               state_in   = frame_ff ? osa_pkg::ST_OUT_RD : osa_pkg::ST_IDLE;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = osa_pkg::ST_LN_RD;
            end
         end
         osa_pkg::ST_OUT_RD: begin
            state_in = osa_pkg::ST_OUT_DIV;
         end
         osa_pkg::ST_OUT_DIV: begin
            neg_in = acc_o[31];
            if (run_sum_ff == 32'd0) begin
               q_in     = 32'd0;
               state_in = osa_pkg::ST_OUT_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = osa_pkg::ST_OUT_WAIT;
            end
         end
         osa_pkg::ST_OUT_WAIT: begin
            if (div_done) begin
               q_in     = (div_quot[47:31] != 17'd0) ? 32'h7FFFFFFF : div_quot[31:0];
               state_in = osa_pkg::ST_OUT_EMIT;
            end
         end
         osa_pkg::ST_OUT_EMIT: begin
            rsp_valid = 1'b1;
            if (lane_ff == dim - 1'b1) begin
               vld_in     = '0;
               dot_in     = 40'sd0;
               run_max_in = 32'sh80000000;
               run_sum_in = 32'd0;
               first_in   = 1'b1;
               lane_in    = '0;
               state_in   = osa_pkg::ST_IDLE;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = osa_pkg::ST_OUT_RD;
            end
         end
         default: begin
            state_in = osa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_data.out_index = 6'(lane_ff);
   assign rsp_data.out_value = osa_pkg::q_to_bf(neg_ff, q_ff);
   assign rsp_data.out_last  = (lane_ff == dim - 1'b1);
   assign busy               = (state_ff != osa_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= osa_pkg::ST_IDLE;
         row_len_ff  <= osa_pkg::ROW_LEN_RST;
         scale_ff    <= osa_pkg::SCORE_SCALE_RST;
         dot_ff      <= 40'sd0;
         run_max_ff  <= 32'sh80000000;
         run_sum_ff  <= 32'd0;
         first_ff    <= 1'b1;
         vld_ff      <= '0;
         lane_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         dot_ff     <= dot_in;
         run_max_ff <= run_max_in;
         run_sum_ff <= run_sum_in;
         first_ff   <= first_in;
         vld_ff     <= vld_in;
         lane_ff    <= lane_in;
         if (csr_we) begin
            case (osa_pkg::csr_index_type'(csr_index))
               osa_pkg::CSR_ROW_LEN:     row_len_ff <= csr_wdata[6:0];
               osa_pkg::CSR_SCORE_SCALE: scale_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      frame_ff   <= frame_in;
      mul_p_ff   <= mul_a * mul_b;
      hi_p_ff    <= hi_p_in;
      score_ff   <= score_in;
      nmax_ff    <= nmax_in;
      exp_d_ff   <= exp_d_in;
      exp_sel_ff <= exp_sel_in;
      alpha_ff   <= alpha_in;
      beta_ff    <= beta_in;
      lane_p_ff  <= lane_p_in;
      q_ff       <= q_in;
      neg_ff     <= neg_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |=> !rsp_valid && !busy)
      else $error("activity after the last result of a frame");

   a_query_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.mode |=> !busy)
      else $error("query load did not finish in one cycle");

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |=> first_ff && (vld_ff == '0))
      else $error("running state not cleared after a frame");
`endif

endmodule
